/* hdl/ntcs_pkg.sv */
// ----------------------------------------------------------------------------
// ntcs_pkg
// Shared types and constants for the nearest-three cluster selector.
// ----------------------------------------------------------------------------
`default_nettype none

package ntcs_pkg;

  // Field widths of the transaction payloads.
  localparam int IdxW   = 4;
  localparam int TotalW = 48;
  localparam int SizeW  = 17;
  localparam int MeanW  = 32;
  localparam int LabelW = 5;

  // Cluster indexes at or above this count are ignored.
  localparam int NumClusters = 16;

  // Mean encodings: all ones is infinity, saturated finite means stop one below.
  localparam logic [MeanW-1:0]  MeanInf   = '1;
  localparam logic [MeanW-1:0]  MeanSat   = MeanInf - MeanW'(1);
  localparam logic [LabelW-1:0] LabelNone = '1;

  // Division steps for the integer part that remains after the overflow check.
  localparam int DivSteps = MeanW;
  localparam int DivCntW  = $clog2(DivSteps);

  // What the back end has to do with one element.
  typedef enum logic [1:0] {
    KindSkip,    // out of range or empty other cluster
    KindOther,   // other cluster, mean = total / size
    KindOwn,     // own cluster, mean = total / (size - 1)
    KindOwnInf   // own cluster of size one or less
  } kind_e;

  // One classified element as it travels through the queue.
  typedef struct packed {
    kind_e             kind;
    logic [IdxW-1:0]   label;
    logic [TotalW-1:0] total;
    logic [SizeW-1:0]  den;
    logic              last;
  } item_t;

  // Back-end sequencer states.
  typedef enum logic [1:0] {
    StIdle,
    StDiv,
    StApply
  } back_state_e;

endpackage

`default_nettype wire

/* hdl/nearest_three_cluster_select.sv */
// ----------------------------------------------------------------------------
// nearest_three_cluster_select
// Keeps the three smallest other-cluster mean distances of a point and its
// own-cluster mean, and reports them when the row's last element arrives.
// ----------------------------------------------------------------------------
//
//  Channel | Handshake               | Payload
//  --------+-------------------------+------------------------------------------
//  in      | in_valid_i / in_ready_o | cluster_index, own_cluster, cluster_total,
//          |                         | cluster_size, row_last
//  out     | out_valid_o/out_ready_i | nearest/second/third mean and label,
//          |                         | own_mean
//
//  An element passes through the back end without a division when none is
//  needed or when the quotient saturates; otherwise the divider resolves
//  one quotient bit per cycle over 32 steps.
//  The front accepts elements into a QueueDepth-entry queue while the back
//  end divides, so the input stalls only when the queue is full.
//  A row's result waits in the output register; the back end stalls on the
//  next row end only while that register is still occupied.
//  Reset clears the kept list to infinity with no label and the own mean to
//  infinity; no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module nearest_three_cluster_select
  import ntcs_pkg::*;
#(
  parameter int QueueDepth = 2
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire logic [IdxW-1:0]     cluster_index_i,
  input  wire logic [IdxW-1:0]     own_cluster_i,
  input  wire logic [TotalW-1:0]   cluster_total_i,
  input  wire logic [SizeW-1:0]    cluster_size_i,
  input  wire logic                row_last_i,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output logic [MeanW-1:0]         nearest_mean_o,
  output logic signed [LabelW-1:0] nearest_label_o,
  output logic [MeanW-1:0]         second_mean_o,
  output logic signed [LabelW-1:0] second_label_o,
  output logic [MeanW-1:0]         third_mean_o,
  output logic signed [LabelW-1:0] third_label_o,
  output logic [MeanW-1:0]         own_mean_o
);

  logic  q_full;
  logic  q_empty;
  logic  q_push;
  logic  q_pop;
  item_t q_wr_item;
  item_t q_rd_item;

  // Front end: handshake and classification.
  ntcs_front u_front (
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .cluster_index_i (cluster_index_i),
    .own_cluster_i   (own_cluster_i),
    .cluster_total_i (cluster_total_i),
    .cluster_size_i  (cluster_size_i),
    .row_last_i      (row_last_i),
    .q_full_i        (q_full),
    .q_push_o        (q_push),
    .q_item_o        (q_wr_item)
  );

  // Queue between the two halves.
  ntcs_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .item_i  (q_wr_item),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .item_o  (q_rd_item),
    .empty_o (q_empty)
  );

  // Back end: divider, top-three list and output register.
  ntcs_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .q_empty_i       (q_empty),
    .q_item_i        (q_rd_item),
    .q_pop_o         (q_pop),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .nearest_mean_o  (nearest_mean_o),
    .nearest_label_o (nearest_label_o),
    .second_mean_o   (second_mean_o),
    .second_label_o  (second_label_o),
    .third_mean_o    (third_mean_o),
    .third_label_o   (third_label_o),
    .own_mean_o      (own_mean_o)
  );

endmodule

`default_nettype wire

/* hdl/ntcs_front.sv */
// ----------------------------------------------------------------------------
// ntcs_front
// Accepts input transactions and classifies each element for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module ntcs_front
  import ntcs_pkg::*;
(
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic [IdxW-1:0]   cluster_index_i,
  input  wire logic [IdxW-1:0]   own_cluster_i,
  input  wire logic [TotalW-1:0] cluster_total_i,
  input  wire logic [SizeW-1:0]  cluster_size_i,
  input  wire logic              row_last_i,
  input  wire logic              q_full_i,
  output logic                   q_push_o,
  output item_t                  q_item_o
);

  logic in_range;
  logic is_own;

  // The element is taken whenever the queue has room.
  assign in_ready_o = !q_full_i;
  assign q_push_o   = in_valid_i && !q_full_i;

  assign in_range = 32'(cluster_index_i) < NumClusters;
  assign is_own   = cluster_index_i == own_cluster_i;

  // Classify the element and pick the divisor.
  always_comb begin
    q_item_o.label = cluster_index_i;
    q_item_o.total = cluster_total_i;
    q_item_o.last  = row_last_i;
    q_item_o.den   = cluster_size_i;
    q_item_o.kind  = KindSkip;
    if (in_range && is_own) begin
      if (cluster_size_i > SizeW'(1)) begin
        q_item_o.kind = KindOwn;
        q_item_o.den  = cluster_size_i - SizeW'(1);
      end else begin
        q_item_o.kind = KindOwnInf;
      end
    end else if (in_range && (cluster_size_i != '0)) begin
      q_item_o.kind = KindOther;
    end
  end

endmodule

`default_nettype wire

/* hdl/ntcs_queue.sv */
// ----------------------------------------------------------------------------
// ntcs_queue
// Short queue of classified elements between the front and the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module ntcs_queue
  import ntcs_pkg::*;
#(
  parameter int Depth = 2
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  push_i,
  input  item_t      item_i,
  output logic       full_o,
  input  wire logic  pop_i,
  output item_t      item_o,
  output logic       empty_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  item_t           slots_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;

  assign full_o  = count_q == CntW'(Depth);
  assign empty_o = count_q == '0;
  assign item_o  = slots_q[rd_ptr_q];

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push_i && !pop_i) begin
      count_d = count_q + CntW'(1);
    end else if (!push_i && pop_i) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Storage slots.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slots_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

`default_nettype wire

/* hdl/ntcs_back.sv */
// ----------------------------------------------------------------------------
// ntcs_back
// Divides, keeps the three smallest means and the own mean, and emits a row.
// ----------------------------------------------------------------------------
`default_nettype none

module ntcs_back
  import ntcs_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               q_empty_i,
  input  item_t                   q_item_i,
  output logic                    q_pop_o,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic [MeanW-1:0]        nearest_mean_o,
  output logic signed [LabelW-1:0] nearest_label_o,
  output logic [MeanW-1:0]        second_mean_o,
  output logic signed [LabelW-1:0] second_label_o,
  output logic [MeanW-1:0]        third_mean_o,
  output logic signed [LabelW-1:0] third_label_o,
  output logic [MeanW-1:0]        own_mean_o
);

  back_state_e        state_q, state_d;
  item_t              ent_q, ent_d;
  logic [SizeW-1:0]   rem_q, rem_d;
  logic [MeanW-1:0]   qn_q, qn_d;
  logic [DivCntW-1:0] cnt_q, cnt_d;

  logic [MeanW-1:0]  means_q  [3];
  logic [MeanW-1:0]  means_d  [3];
  logic [LabelW-1:0] labels_q [3];
  logic [LabelW-1:0] labels_d [3];
  logic [MeanW-1:0]  within_q, within_d;

  logic [MeanW-1:0]  upd_means  [3];
  logic [LabelW-1:0] upd_labels [3];
  logic [MeanW-1:0]  upd_within;

  logic              out_valid_q, out_valid_d;
  logic              out_load;

  logic [SizeW:0]    rem_sh;
  logic              q_bit;
  logic [SizeW-1:0]  rem_step;
  logic [MeanW-1:0]  qn_step;
  logic              ovf;
  logic [LabelW-1:0] new_label;

  // One restoring division step: shift in the next numerator bit, try subtract.
  assign rem_sh   = {rem_q, qn_q[MeanW-1]};
  assign q_bit    = rem_sh >= {1'b0, ent_q.den};
  assign rem_step = q_bit ? SizeW'(rem_sh - {1'b0, ent_q.den}) : rem_sh[SizeW-1:0];
  assign qn_step  = {qn_q[MeanW-2:0], q_bit};

  // The quotient needs more than 32 bits when the top numerator part reaches den.
  assign ovf = {1'b0, q_item_i.total[TotalW-1:MeanW]} >= q_item_i.den;

  assign new_label = {1'b0, ent_q.label};

  // Compare-insert into the sorted three-entry list; ties keep the older entry.
  always_comb begin
    upd_means  = means_q;
    upd_labels = labels_q;
    upd_within = within_q;
    case (ent_q.kind)
      KindOther: begin
        if (qn_q < means_q[0]) begin
          upd_means[2]  = means_q[1];
          upd_labels[2] = labels_q[1];
          upd_means[1]  = means_q[0];
          upd_labels[1] = labels_q[0];
          upd_means[0]  = qn_q;
          upd_labels[0] = new_label;
        end else if (qn_q < means_q[1]) begin
          upd_means[2]  = means_q[1];
          upd_labels[2] = labels_q[1];
          upd_means[1]  = qn_q;
          upd_labels[1] = new_label;
        end else if (qn_q < means_q[2]) begin
          upd_means[2]  = qn_q;
          upd_labels[2] = new_label;
        end
      end
      KindOwn, KindOwnInf: begin
        upd_within = qn_q;
      end
      default: begin
      end
    endcase
  end

  // Sequencer: fetch, divide, apply and emit.
  always_comb begin
    state_d     = state_q;
    ent_d       = ent_q;
    rem_d       = rem_q;
    qn_d        = qn_q;
    cnt_d       = cnt_q;
    means_d     = means_q;
    labels_d    = labels_q;
    within_d    = within_q;
    q_pop_o     = 1'b0;
    out_load    = 1'b0;
    out_valid_d = out_valid_q && !out_ready_i;
    unique case (state_q)
      StIdle: begin
        if (!q_empty_i) begin
          q_pop_o = 1'b1;
          ent_d   = q_item_i;
          state_d = StApply;
          if ((q_item_i.kind == KindOther) || (q_item_i.kind == KindOwn)) begin
            if (ovf) begin
              qn_d = MeanSat;
            end else begin
              rem_d   = {1'b0, q_item_i.total[TotalW-1:MeanW]};
              qn_d    = q_item_i.total[MeanW-1:0];
              cnt_d   = '0;
              state_d = StDiv;
            end
          end else begin
            qn_d = MeanInf;
          end
        end
      end
      StDiv: begin
        rem_d = rem_step;
        qn_d  = qn_step;
        cnt_d = cnt_q + DivCntW'(1);
        if (cnt_q == DivCntW'(DivSteps - 1)) begin
          qn_d    = (qn_step == MeanInf) ? MeanSat : qn_step;
          state_d = StApply;
        end
      end
      StApply: begin
        if (!ent_q.last) begin
          means_d  = upd_means;
          labels_d = upd_labels;
          within_d = upd_within;
          state_d  = StIdle;
        end else if (!out_valid_q || out_ready_i) begin
          out_load    = 1'b1;
          out_valid_d = 1'b1;
          means_d     = '{MeanInf, MeanInf, MeanInf};
          labels_d    = '{LabelNone, LabelNone, LabelNone};
          within_d    = MeanInf;
          state_d     = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
      means_q     <= '{MeanInf, MeanInf, MeanInf};
      labels_q    <= '{LabelNone, LabelNone, LabelNone};
      within_q    <= MeanInf;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      means_q     <= means_d;
      labels_q    <= labels_d;
      within_q    <= within_d;
    end
  end

  // Working registers of the divider.
  always_ff @(posedge clk_i) begin
    ent_q <= ent_d;
    rem_q <= rem_d;
    qn_q  <= qn_d;
    cnt_q <= cnt_d;
  end

  // Output register, loaded with the row's final list.
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      nearest_mean_o  <= upd_means[0];
      nearest_label_o <= upd_labels[0];
      second_mean_o   <= upd_means[1];
      second_label_o  <= upd_labels[1];
      third_mean_o    <= upd_means[2];
      third_label_o   <= upd_labels[2];
      own_mean_o      <= upd_within;
    end
  end

  assign out_valid_o = out_valid_q;

`ifndef SYNTHESIS
  // The kept list stays in ascending order.
  a_sorted : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (means_q[0] <= means_q[1]) && (means_q[1] <= means_q[2]))
    else $error("best means out of order");

  // An empty list slot always reads as infinity.
  a_none_inf : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((labels_q[0] != LabelNone) || (means_q[0] == MeanInf)) &&
    ((labels_q[1] != LabelNone) || (means_q[1] == MeanInf)) &&
    ((labels_q[2] != LabelNone) || (means_q[2] == MeanInf)))
    else $error("empty slot holds a finite mean");

  // A new row result is only loaded when the output register is free.
  a_no_overwrite : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load |-> (!out_valid_q || out_ready_i)))
    else $error("row result overwritten");

  // The queue is popped only from the idle state.
  a_pop_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (q_pop_o |-> (state_q == StIdle) && !q_empty_i))
    else $error("queue popped outside idle");
`endif

endmodule

`default_nettype wire
